### sv/protection_level_margin_cost_assert.svh
// Assertion macros shared by the checker files.
// PLMC_ASSERT holds outside reset; PLMC_ASSERT_RST is sampled in reset too.
`ifndef PROTECTION_LEVEL_MARGIN_COST_ASSERT_SVH
`define PROTECTION_LEVEL_MARGIN_COST_ASSERT_SVH

`define PLMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define PLMC_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/plmc_pkg.sv
// ----------------------------------------------------------------------------
// plmc_pkg
// Types, register indexes and constants of the protection level margin cost
// evaluator.
// ----------------------------------------------------------------------------
package plmc_pkg;

	// default widths
	localparam int LENGTH_BITS_DEF = 24;
	localparam int COST_BITS_DEF   = 48;

	// queue depth between front and back, and on the result side
	localparam int QUEUE_DEPTH = 2;

	// fixed point formats
	localparam int GAIN_BITS   = 16;
	localparam int GAIN_SHIFT  = 8;
	localparam int RATIO_FRAC  = 16;
	localparam int RATIO_SHIFT = 24;

	// register reset values
	localparam logic [3:0]  MODE_RESET      = 4'd13;
	localparam logic [31:0] MAX_COST_RESET  = 32'd196608000;
	localparam logic [31:0] EPS_LIMIT_RESET = 32'd1;
	localparam logic [31:0] MARGIN_RESET    = 32'd256;
	localparam logic [15:0] GAIN_RESET      = 16'd256;
	localparam logic [15:0] MU_RESET        = 16'd0;

	typedef enum logic [2:0] {
		REG_MODE_FLAGS = 3'd0,
		REG_MAX_COST   = 3'd1,
		REG_EPS_LIMIT  = 3'd2,
		REG_MARGIN_H   = 3'd3,
		REG_MARGIN_V   = 3'd4,
		REG_GAIN_H     = 3'd5,
		REG_GAIN_V     = 3'd6,
		REG_MU_RATIO   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic ratio;
		logic hinge;
		logic penalize;
		logic unified;
	} mode_t;

	typedef enum logic [1:0] {
		RISK_NONE     = 2'd0,
		RISK_SAFE     = 2'd1,
		RISK_MARGINAL = 2'd2,
		RISK_UNSAFE   = 2'd3
	} risk_t;

	typedef enum logic [1:0] {
		AXIS_NONE     = 2'd0,
		AXIS_BALANCED = 2'd1,
		AXIS_HORIZ    = 2'd2,
		AXIS_VERT     = 2'd3
	} axis_t;

	// classification of one item, from front to back
	typedef struct packed {
		logic  ok;
		logic  pen;
		logic  ren;
		logic  unified;
		risk_t risk;
		axis_t dom;
	} item_ctl_t;

endpackage

### sv/plmc_fifo.sv
// ----------------------------------------------------------------------------
// plmc_fifo
// Small register queue; head shown combinationally while not empty.
// ----------------------------------------------------------------------------
module plmc_fifo import plmc_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	// DEPTH is a power of two so the pointers wrap naturally
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop)  rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

endmodule

### sv/plmc_front.sv
// ----------------------------------------------------------------------------
// plmc_front
// Accepts items, checks validity, forms margins, risk band, dominant axis,
// hinge exceedances and ratio denominators, and queues them for the back.
// ----------------------------------------------------------------------------
module plmc_front import plmc_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input beats
	input  logic                   push,
	output logic                   full,
	input  logic [LENGTH_BITS-1:0] alert_h,
	input  logic [LENGTH_BITS-1:0] alert_v,
	input  logic [LENGTH_BITS-1:0] prot_h,
	input  logic [LENGTH_BITS-1:0] prot_v,
	input  logic                   all_finite,
	// configuration
	input  mode_t                  mode,
	input  logic [LENGTH_BITS-1:0] eps_limit,
	input  logic [LENGTH_BITS-1:0] hinge_off_h,
	input  logic [LENGTH_BITS-1:0] hinge_off_v,
	// queue towards the back
	output logic                   q_valid,
	input  logic                   q_pop,
	output item_ctl_t              q_ctl,
	output logic signed [LENGTH_BITS:0] q_mh,
	output logic signed [LENGTH_BITS:0] q_mv,
	output logic signed [LENGTH_BITS:0] q_mmin,
	output logic [LENGTH_BITS:0]   q_eh,
	output logic [LENGTH_BITS:0]   q_ev,
	output logic [LENGTH_BITS-1:0] q_ph,
	output logic [LENGTH_BITS-1:0] q_pv,
	output logic [LENGTH_BITS:0]   q_dh,
	output logic [LENGTH_BITS:0]   q_dv
);

	localparam int L  = LENGTH_BITS;
	localparam int CW = $bits(item_ctl_t);
	localparam int IW = CW + 7*(L+1) + 2*L;

	item_ctl_t          ctl;
	logic               ok, hinge_on, lt, q_empty;
	logic [L-1:0]       off_v, thr_v;
	logic [L+1:0]       ex_h, ex_v;
	logic [L:0]         e_h, e_v, den_h, den_v;
	logic signed [L:0]  mh, mv, mmin, mh_raw, mv_raw;
	logic [IW-1:0]      wdata, rdata;

	// classification
	always_comb begin
		ok       = all_finite && (!mode.unified || (alert_h > eps_limit && alert_v > eps_limit));
		hinge_on = !mode.unified || mode.hinge;
		off_v    = mode.unified ? hinge_off_v : hinge_off_h;
		thr_v    = off_v;

		// hinge exceedance prot - alert + offset, kept only when positive
		ex_h = {2'b0, prot_h} + {2'b0, hinge_off_h} - {2'b0, alert_h};
		ex_v = {2'b0, prot_v} + {2'b0, off_v} - {2'b0, alert_v};
		e_h  = (ok && hinge_on && !ex_h[L+1]) ? ex_h[L:0] : '0;
		e_v  = (ok && hinge_on && !ex_v[L+1]) ? ex_v[L:0] : '0;

		den_h = {1'b0, alert_h} + {1'b0, eps_limit};
		den_v = {1'b0, alert_v} + {1'b0, eps_limit};

		mh_raw = $signed({1'b0, alert_h}) - $signed({1'b0, prot_h});
		mv_raw = $signed({1'b0, alert_v}) - $signed({1'b0, prot_v});
		lt     = mh_raw < mv_raw;
		mh     = ok ? mh_raw : '0;
		mv     = ok ? mv_raw : '0;
		mmin   = ok ? (lt ? mh_raw : mv_raw) : '0;

		ctl.ok      = ok;
		ctl.pen     = !ok && mode.unified && mode.penalize;
		ctl.ren     = ok && mode.unified && mode.ratio;
		ctl.unified = mode.unified;

		// risk band
		if (!ok)
			ctl.risk = RISK_NONE;
		else if (mh_raw[L] || mv_raw[L])
			ctl.risk = RISK_UNSAFE;
		else if (mh_raw < $signed({1'b0, hinge_off_h}) || mv_raw < $signed({1'b0, thr_v}))
			ctl.risk = RISK_MARGINAL;
		else
			ctl.risk = RISK_SAFE;

		// tighter axis
		if (!ok)                ctl.dom = AXIS_NONE;
		else if (mh_raw == mv_raw) ctl.dom = AXIS_BALANCED;
		else if (lt)            ctl.dom = AXIS_HORIZ;
		else                    ctl.dom = AXIS_VERT;
	end

	assign wdata = {ctl, mh, mv, mmin, e_h, e_v, prot_h, prot_v, den_h, den_v};

	plmc_fifo #(.W(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wdata),
		.full  (full),
		.pop   (q_pop),
		.rdata (rdata),
		.empty (q_empty)
	);

	assign q_valid = !q_empty;
	assign {q_ctl, q_mh, q_mv, q_mmin, q_eh, q_ev, q_ph, q_pv, q_dh, q_dv} = rdata;

endmodule

### sv/plmc_back.sv
// ----------------------------------------------------------------------------
// plmc_back
// Pipelined restoring dividers for the two ratios, then multiplier stages for
// the hinge and ratio costs, saturating sums, clamp, and the result queue.
// The whole pipeline holds while the result queue is full.
// ----------------------------------------------------------------------------
module plmc_back import plmc_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int COST_BITS   = COST_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// from the front queue
	input  logic                   q_valid,
	output logic                   q_pop,
	input  item_ctl_t              q_ctl,
	input  logic signed [LENGTH_BITS:0] q_mh,
	input  logic signed [LENGTH_BITS:0] q_mv,
	input  logic signed [LENGTH_BITS:0] q_mmin,
	input  logic [LENGTH_BITS:0]   q_eh,
	input  logic [LENGTH_BITS:0]   q_ev,
	input  logic [LENGTH_BITS-1:0] q_ph,
	input  logic [LENGTH_BITS-1:0] q_pv,
	input  logic [LENGTH_BITS:0]   q_dh,
	input  logic [LENGTH_BITS:0]   q_dv,
	// configuration
	input  logic [COST_BITS-1:0]   cost_cap,
	input  logic [GAIN_BITS-1:0]   gain_h,
	input  logic [GAIN_BITS-1:0]   gain_v,
	input  logic [GAIN_BITS-1:0]   ratio_gain,
	// result beats
	output logic                   empty,
	input  logic                   pop,
	output logic                   valid_out,
	output logic                   input_ok,
	output logic signed [LENGTH_BITS:0] margin_h_out,
	output logic signed [LENGTH_BITS:0] margin_v_out,
	output logic signed [LENGTH_BITS:0] min_margin,
	output logic [COST_BITS-1:0]   cost_h,
	output logic [COST_BITS-1:0]   cost_v,
	output logic [COST_BITS-1:0]   ratio_pen,
	output logic [COST_BITS-1:0]   total_cost,
	output logic                   clamp_hit,
	output logic [1:0]             risk_code,
	output logic [1:0]             tight_axis
);

	localparam int L    = LENGTH_BITS;
	localparam int C    = COST_BITS;
	localparam int NB   = L + RATIO_FRAC;         // quotient bits
	localparam int HW   = (NB + 1) / 2;           // low half of the quotient
	localparam int MRW  = GAIN_BITS + NB;
	localparam int RSW  = MRW + NB;
	localparam int REXT = RSW + C;
	localparam int SQW  = 2 * (L + 1);
	localparam int HGW  = SQW + GAIN_BITS;
	localparam int HEXT = HGW + C;
	localparam int CW   = $bits(item_ctl_t);
	localparam int SBW  = CW + 5 * (L + 1);
	localparam int OW   = 1 + 4*C + 1 + 4 + 3*(L+1);

	function automatic logic [C-1:0] sat_add(input logic [C-1:0] a, input logic [C-1:0] b);
		logic [C:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[C] ? '1 : s[C-1:0];
	endfunction

	logic en, out_full;

	assign en    = !out_full;
	assign q_pop = en && q_valid;

	// ---------------- divider stages ----------------
	logic [L:0]     cur_rem [2][NB];
	logic [L:0]     cur_den [2][NB];
	logic [NB-1:0]  cur_nq  [2][NB];
	logic [L+1:0]   trial   [2][NB];
	logic           ge      [2][NB];
	logic [L:0]     nxt_rem [2][NB];
	logic [NB-1:0]  nxt_nq  [2][NB];
	logic [SBW-1:0] cur_sb  [NB];
	logic           cur_vld [NB];

	logic [L:0]     rem_s [2][1:NB-1];
	logic [L:0]     den_s [2][1:NB-1];
	logic [NB-1:0]  nq_s  [2][1:NB];
	logic [SBW-1:0] sb_s  [1:NB];
	logic           vld_s [1:NB];

	always_comb begin
		// stage 0 comes from the queue head
		cur_rem[0][0] = '0;
		cur_rem[1][0] = '0;
		cur_nq[0][0]  = {q_ph, {RATIO_FRAC{1'b0}}};
		cur_nq[1][0]  = {q_pv, {RATIO_FRAC{1'b0}}};
		cur_den[0][0] = q_dh;
		cur_den[1][0] = q_dv;
		cur_sb[0]     = {q_ctl, q_mh, q_mv, q_mmin, q_eh, q_ev};
		cur_vld[0]    = q_valid;
		for (int k = 1; k < NB; k++) begin
			for (int a = 0; a < 2; a++) begin
				cur_rem[a][k] = rem_s[a][k];
				cur_den[a][k] = den_s[a][k];
				cur_nq[a][k]  = nq_s[a][k];
			end
			cur_sb[k]  = sb_s[k];
			cur_vld[k] = vld_s[k];
		end
		// one quotient bit per stage
		for (int k = 0; k < NB; k++) begin
			for (int a = 0; a < 2; a++) begin
				trial[a][k]   = {cur_rem[a][k], cur_nq[a][k][NB-1]};
				ge[a][k]      = trial[a][k] >= {1'b0, cur_den[a][k]};
				nxt_rem[a][k] = ge[a][k] ? (L+1)'(trial[a][k] - {1'b0, cur_den[a][k]})
				                         : trial[a][k][L:0];
				nxt_nq[a][k]  = {cur_nq[a][k][NB-2:0], ge[a][k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NB; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < NB; k++) vld_s[k+1] <= cur_vld[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NB; k++) begin
				for (int a = 0; a < 2; a++) nq_s[a][k+1] <= nxt_nq[a][k];
				sb_s[k+1] <= cur_sb[k];
			end
			// the last stage needs no remainder
			for (int k = 0; k < NB - 1; k++) begin
				for (int a = 0; a < 2; a++) begin
					rem_s[a][k+1] <= nxt_rem[a][k];
					den_s[a][k+1] <= cur_den[a][k];
				end
			end
		end
	end

	// ---------------- cost stages ----------------
	item_ctl_t         ctl_s1, ctl_s3;
	logic [L:0]        e_d [2];

	assign {e_d[0], e_d[1]} = sb_s[NB][2*(L+1)-1:0];

	logic [MRW-1:0]       mr_s1 [2];
	logic [NB-1:0]        rq_s1 [2];
	logic [SQW-1:0]       sq_s1 [2];
	logic [SBW-1:0]       sb_s1, sb_s2, sb_s3, sb_s4;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [MRW+HW-1:0]    plo_s2 [2];
	logic [MRW+NB-HW-1:0] phi_s2 [2];
	logic [HGW-1:0]       hg_s2  [2];
	logic [RSW-1:0]       rsum   [2];
	logic [REXT-1:0]      rx     [2];
	logic [HEXT-1:0]      hx     [2];
	logic [C-1:0]         rt_s3  [2];
	logic [C-1:0]         hc_s3  [2];
	logic [C-1:0]         hc_s4  [2];
	logic [C-1:0]         rc_s4, hs_s4;
	logic [GAIN_BITS-1:0] gain_sel [2];

	assign ctl_s1 = item_ctl_t'(sb_s1[SBW-1 -: CW]);
	assign ctl_s3 = item_ctl_t'(sb_s3[SBW-1 -: CW]);
	assign gain_sel[0] = gain_h;
	assign gain_sel[1] = ctl_s1.unified ? gain_h : gain_v;

	// ratio and hinge saturation after the shift
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			rsum[a] = RSW'(plo_s2[a]) + (RSW'(phi_s2[a]) << HW);
			rx[a]   = REXT'(rsum[a]) >> RATIO_SHIFT;
			hx[a]   = HEXT'(hg_s2[a]) >> GAIN_SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_s[NB];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				// s1: mu * R and e squared
				mr_s1[a] <= MRW'(ratio_gain) * MRW'(nq_s[a][NB]);
				rq_s1[a] <= nq_s[a][NB];
				sq_s1[a] <= SQW'(e_d[a]) * SQW'(e_d[a]);
				// s2: partial products of mu * R * R, gain on e squared
				plo_s2[a] <= (MRW+HW)'(mr_s1[a]) * (MRW+HW)'(rq_s1[a][HW-1:0]);
				phi_s2[a] <= (MRW+NB-HW)'(mr_s1[a]) * (MRW+NB-HW)'(rq_s1[a][NB-1:HW]);
				hg_s2[a]  <= HGW'(sq_s1[a]) * HGW'(gain_sel[a]);
				// s3: shift and saturate
				rt_s3[a] <= (|rx[a][REXT-1:C]) ? '1 : rx[a][C-1:0];
				hc_s3[a] <= (|hx[a][HEXT-1:C]) ? '1 : hx[a][C-1:0];
				hc_s4[a] <= hc_s3[a];
			end
			// s4: per-term sums
			rc_s4 <= ctl_s3.ren ? sat_add(rt_s3[0], rt_s3[1]) : '0;
			hs_s4 <= sat_add(hc_s3[0], hc_s3[1]);
			sb_s1 <= sb_s[NB];
			sb_s2 <= sb_s1;
			sb_s3 <= sb_s2;
			sb_s4 <= sb_s3;
		end
	end

	// ---------------- total, clamp, result queue ----------------
	item_ctl_t         ctl_f;
	logic signed [L:0] mh_f, mv_f, mmin_f;
	logic [C-1:0]      total_raw, total;
	logic              clamp;
	logic [OW-1:0]     owdata, ordata;
	logic              ok_o;

	// exceedances are not needed past the multipliers
	assign {ctl_f, mh_f, mv_f, mmin_f} = sb_s4[SBW-1 -: CW + 3*(L+1)];

	always_comb begin
		total_raw = sat_add(hs_s4, rc_s4);
		clamp     = ctl_f.unified && !ctl_f.pen && (total_raw > cost_cap);
		if (ctl_f.pen || clamp) total = cost_cap;
		else                    total = total_raw;
	end

	assign owdata = {ctl_f.ok, hc_s4[0], hc_s4[1], rc_s4, total, clamp,
	                 ctl_f.risk, ctl_f.dom, mh_f, mv_f, mmin_f};

	plmc_fifo #(.W(OW), .DEPTH(QUEUE_DEPTH)) u_results (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (en && vld_s4),
		.wdata (owdata),
		.full  (out_full),
		.pop   (pop),
		.rdata (ordata),
		.empty (empty)
	);

	assign {ok_o, cost_h, cost_v, ratio_pen, total_cost, clamp_hit,
	        risk_code, tight_axis, margin_h_out, margin_v_out, min_margin} = ordata;
	assign valid_out = ok_o;
	assign input_ok  = ok_o;

endmodule

### sv/protection_level_margin_cost.sv
// ----------------------------------------------------------------------------
// protection_level_margin_cost
// Protection level margin cost evaluator: margins, hinge and ratio costs,
// clamped total, risk band and dominant axis for each item.
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// ----------+----------------------+-----------------------------------------
// input     | push / full          | alert_h alert_v prot_h prot_v all_finite
// result    | pop / empty          | valid_out .. tight_axis
// config    | wr_en                | wr_index, wr_data
//
// One item per cycle sustained while the result queue is not full; the
// divider pipeline resolves one quotient bit per stage and is followed
// by four multiply and sum stages.
// Reset clears queues and pipeline valids and loads register defaults.
// A full result queue holds the back pipeline; the front then fills its
// two-entry queue and raises full.
// ----------------------------------------------------------------------------
module protection_level_margin_cost import plmc_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int COST_BITS   = COST_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   wr_en,
	input  logic [2:0]             wr_index,
	input  logic [COST_BITS-1:0]   wr_data,
	// input beats
	input  logic                   push,
	output logic                   full,
	input  logic [LENGTH_BITS-1:0] alert_h,
	input  logic [LENGTH_BITS-1:0] alert_v,
	input  logic [LENGTH_BITS-1:0] prot_h,
	input  logic [LENGTH_BITS-1:0] prot_v,
	input  logic                   all_finite,
	// result beats
	output logic                   empty,
	input  logic                   pop,
	output logic                   valid_out,
	output logic                   input_ok,
	output logic signed [LENGTH_BITS:0] margin_h_out,
	output logic signed [LENGTH_BITS:0] margin_v_out,
	output logic signed [LENGTH_BITS:0] min_margin,
	output logic [COST_BITS-1:0]   cost_h,
	output logic [COST_BITS-1:0]   cost_v,
	output logic [COST_BITS-1:0]   ratio_pen,
	output logic [COST_BITS-1:0]   total_cost,
	output logic                   clamp_hit,
	output logic [1:0]             risk_code,
	output logic [1:0]             tight_axis
);

	localparam int L = LENGTH_BITS;
	localparam int C = COST_BITS;

	mode_t                mode_q;
	logic [C-1:0]         max_cost_q;
	logic [L-1:0]         eps_q, margin_h_q, margin_v_q;
	logic [GAIN_BITS-1:0] gain_h_q, gain_v_q, mu_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= mode_t'(MODE_RESET);
			max_cost_q <= C'(MAX_COST_RESET);
			eps_q      <= L'(EPS_LIMIT_RESET);
			margin_h_q <= L'(MARGIN_RESET);
			margin_v_q <= L'(MARGIN_RESET);
			gain_h_q   <= GAIN_RESET;
			gain_v_q   <= GAIN_RESET;
			mu_q       <= MU_RESET;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MODE_FLAGS: mode_q     <= mode_t'(wr_data[3:0]);
				REG_MAX_COST:   max_cost_q <= wr_data;
				REG_EPS_LIMIT:  eps_q      <= wr_data[L-1:0];
				REG_MARGIN_H:   margin_h_q <= wr_data[L-1:0];
				REG_MARGIN_V:   margin_v_q <= wr_data[L-1:0];
				REG_GAIN_H:     gain_h_q   <= wr_data[GAIN_BITS-1:0];
				REG_GAIN_V:     gain_v_q   <= wr_data[GAIN_BITS-1:0];
				REG_MU_RATIO:   mu_q       <= wr_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// front to back
	logic              q_valid, q_pop;
	item_ctl_t         q_ctl;
	logic signed [L:0] q_mh, q_mv, q_mmin;
	logic [L:0]        q_eh, q_ev, q_dh, q_dv;
	logic [L-1:0]      q_ph, q_pv;

	plmc_front #(.LENGTH_BITS(L)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.alert_h    (alert_h),
		.alert_v    (alert_v),
		.prot_h     (prot_h),
		.prot_v     (prot_v),
		.all_finite (all_finite),
		.mode       (mode_q),
		.eps_limit  (eps_q),
		.hinge_off_h(margin_h_q),
		.hinge_off_v(margin_v_q),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_ctl      (q_ctl),
		.q_mh       (q_mh),
		.q_mv       (q_mv),
		.q_mmin     (q_mmin),
		.q_eh       (q_eh),
		.q_ev       (q_ev),
		.q_ph       (q_ph),
		.q_pv       (q_pv),
		.q_dh       (q_dh),
		.q_dv       (q_dv)
	);

	plmc_back #(.LENGTH_BITS(L), .COST_BITS(C)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_ctl        (q_ctl),
		.q_mh         (q_mh),
		.q_mv         (q_mv),
		.q_mmin       (q_mmin),
		.q_eh         (q_eh),
		.q_ev         (q_ev),
		.q_ph         (q_ph),
		.q_pv         (q_pv),
		.q_dh         (q_dh),
		.q_dv         (q_dv),
		.cost_cap     (max_cost_q),
		.gain_h       (gain_h_q),
		.gain_v       (gain_v_q),
		.ratio_gain   (mu_q),
		.empty        (empty),
		.pop          (pop),
		.valid_out    (valid_out),
		.input_ok     (input_ok),
		.margin_h_out (margin_h_out),
		.margin_v_out (margin_v_out),
		.min_margin   (min_margin),
		.cost_h       (cost_h),
		.cost_v       (cost_v),
		.ratio_pen    (ratio_pen),
		.total_cost   (total_cost),
		.clamp_hit    (clamp_hit),
		.risk_code    (risk_code),
		.tight_axis   (tight_axis)
	);

endmodule

### sv/plmc_checker.sv
// ----------------------------------------------------------------------------
// plmc_checker
// Port-level checks on the result side of the evaluator, bound to the top.
// ----------------------------------------------------------------------------
`include "protection_level_margin_cost_assert.svh"

module plmc_checker import plmc_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int COST_BITS   = COST_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   wr_en,
	input logic [2:0]             wr_index,
	input logic [COST_BITS-1:0]   wr_data,
	input logic                   push,
	input logic                   full,
	input logic [LENGTH_BITS-1:0] alert_h,
	input logic [LENGTH_BITS-1:0] alert_v,
	input logic [LENGTH_BITS-1:0] prot_h,
	input logic [LENGTH_BITS-1:0] prot_v,
	input logic                   all_finite,
	input logic                   empty,
	input logic                   pop,
	input logic                   valid_out,
	input logic                   input_ok,
	input logic signed [LENGTH_BITS:0] margin_h_out,
	input logic signed [LENGTH_BITS:0] margin_v_out,
	input logic signed [LENGTH_BITS:0] min_margin,
	input logic [COST_BITS-1:0]   cost_h,
	input logic [COST_BITS-1:0]   cost_v,
	input logic [COST_BITS-1:0]   ratio_pen,
	input logic [COST_BITS-1:0]   total_cost,
	input logic                   clamp_hit,
	input logic [1:0]             risk_code,
	input logic [1:0]             tight_axis
);

	// invalid beats carry no per-term costs, no clamp and no bands
	`PLMC_ASSERT(a_invalid_zero, !empty && !valid_out |-> cost_h == '0 && cost_v == '0 && ratio_pen == '0 && risk_code == RISK_NONE && !clamp_hit, "invalid result carries costs")

	// the smaller margin is the reported minimum
	`PLMC_ASSERT(a_min_margin, !empty && valid_out |-> min_margin == ((margin_h_out < margin_v_out) ? margin_h_out : margin_v_out), "min_margin mismatch")

	// dominant axis is balanced when the margins are equal
	`PLMC_ASSERT(a_axis, !empty && valid_out && margin_h_out == margin_v_out |-> tight_axis == AXIS_BALANCED, "balanced axis missed")

	// a waiting result holds until taken
	`PLMC_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(total_cost) && $stable(min_margin), "waiting result changed")

	// the result queue is empty once reset has been seen at an edge
	`PLMC_ASSERT_RST(a_reset_empty, !arst_n && $past(!arst_n) |-> empty, "result shown during reset")

endmodule

bind protection_level_margin_cost plmc_checker #(
	.LENGTH_BITS(LENGTH_BITS),
	.COST_BITS  (COST_BITS)
) u_plmc_checker (.*);

### dv/protection_level_margin_cost_test.sv
// ----------------------------------------------------------------------------
// protection_level_margin_cost_test
// Self-checking bench for the margin cost evaluator: directed corner items
// and random items across several register settings, each result beat
// compared field by field against an in-bench prediction of the arithmetic.
// ----------------------------------------------------------------------------
module protection_level_margin_cost_test import plmc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LB = 24;
	localparam int CB = 48;
	localparam logic [CB-1:0] COST_SAT = {CB{1'b1}};
	localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

	typedef struct packed {
		logic [LB-1:0] ah;
		logic [LB-1:0] av;
		logic [LB-1:0] ph;
		logic [LB-1:0] pv;
		logic          fin;
	} sample_t;

	typedef struct packed {
		logic          vld;
		logic          ok;
		logic [LB:0]   mh;
		logic [LB:0]   mv;
		logic [LB:0]   mmin;
		logic [CB-1:0] ch;
		logic [CB-1:0] cv;
		logic [CB-1:0] rc;
		logic [CB-1:0] tot;
		logic          clmp;
		logic [1:0]    risk;
		logic [1:0]    dom;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [CB-1:0] wr_data = '0;
	logic push = 1'b0;
	logic full;
	logic [LB-1:0] alert_h = '0, alert_v = '0, prot_h = '0, prot_v = '0;
	logic all_finite = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic valid_out, input_ok, clamp_hit;
	logic signed [LB:0] margin_h_out, margin_v_out, min_margin;
	logic [CB-1:0] cost_h, cost_v, ratio_pen, total_cost;
	logic [1:0] risk_code, tight_axis;

	// shadow copy of the registers
	logic [3:0]    sh_mode = MODE_RESET;
	logic [CB-1:0] sh_max = CB'(MAX_COST_RESET);
	logic [LB-1:0] sh_eps = LB'(EPS_LIMIT_RESET);
	logic [LB-1:0] sh_mh = LB'(MARGIN_RESET);
	logic [LB-1:0] sh_mv = LB'(MARGIN_RESET);
	logic [15:0]   sh_gh = GAIN_RESET, sh_gv = GAIN_RESET, sh_mu = MU_RESET;

	sample_t  pending_samples[$];
	verdict_t expected_verdicts[$];
	int errors = 0;
	bit calm = 0;
	int push_gap = 0, pop_gap = 0;

	protection_level_margin_cost uut (.*);

	always #5 clk = ~clk;

	// floor(a*b / 2^sh) with saturation
	function automatic logic [CB-1:0] scaled_product(logic [127:0] a, logic [127:0] b, int sh);
		logic [127:0] p;
		p = (a * b) >> sh;
		return (p > COST_SAT) ? COST_SAT : p[CB-1:0];
	endfunction

	function automatic logic [CB-1:0] sat_sum(logic [CB-1:0] a, logic [CB-1:0] b);
		logic [CB:0] s;
		s = a + b;
		return s[CB] ? COST_SAT : s[CB-1:0];
	endfunction

	function automatic logic [CB-1:0] hinge_term(logic [LB-1:0] al, logic [LB-1:0] pr,
			logic [LB-1:0] off, logic [15:0] g);
		longint e;
		e = longint'(pr) - longint'(al) + longint'(off);
		if (e <= 0) return '0;
		return scaled_product(128'(e) * g, 128'(e), GAIN_SHIFT);
	endfunction

	function automatic logic [CB-1:0] ratio_cost_term(logic [LB-1:0] al, logic [LB-1:0] pr);
		logic [63:0] den, r;
		den = 64'(al) + 64'(sh_eps);
		if (den == 0) return COST_SAT;
		r = (64'(pr) << RATIO_FRAC) / den;
		return scaled_product(128'(r) * sh_mu, 128'(r), RATIO_SHIFT);
	endfunction

	function automatic verdict_t predict_cost(sample_t s);
		verdict_t v;
		mode_t m;
		longint mh, mv, mm, th, tv;
		logic [CB-1:0] t;
		m = mode_t'(sh_mode);
		v = '0;
		if (m.unified) begin
			if (!(s.fin && s.ah > sh_eps && s.av > sh_eps)) begin
				if (m.penalize) v.tot = sh_max;
				return v;
			end
			if (m.hinge) begin
				v.ch = hinge_term(s.ah, s.ph, sh_mh, sh_gh);
				v.cv = hinge_term(s.av, s.pv, sh_mv, sh_gh);
			end
			if (m.ratio) v.rc = sat_sum(ratio_cost_term(s.ah, s.ph), ratio_cost_term(s.av, s.pv));
			t = sat_sum(sat_sum(v.ch, v.cv), v.rc);
			if (t > sh_max) begin
				t = sh_max;
				v.clmp = 1'b1;
			end
			v.tot = t;
			th = sh_mh;
			tv = sh_mv;
		end else begin
			if (!s.fin) return v;
			v.ch = hinge_term(s.ah, s.ph, sh_mh, sh_gh);
			v.cv = hinge_term(s.av, s.pv, sh_mh, sh_gv);
			v.tot = sat_sum(v.ch, v.cv);
			th = sh_mh;
			tv = sh_mh;
		end
		mh = longint'(s.ah) - longint'(s.ph);
		mv = longint'(s.av) - longint'(s.pv);
		mm = (mh < mv) ? mh : mv;
		if (mh < 0 || mv < 0) v.risk = RISK_UNSAFE;
		else if (mh < th || mv < tv) v.risk = RISK_MARGINAL;
		else v.risk = RISK_SAFE;
		if (mh == mv) v.dom = AXIS_BALANCED;
		else if (mh < mv) v.dom = AXIS_HORIZ;
		else v.dom = AXIS_VERT;
		v.vld = 1'b1;
		v.ok = 1'b1;
		v.mh = mh[LB:0];
		v.mv = mv[LB:0];
		v.mmin = mm[LB:0];
		return v;
	endfunction

	// input driver
	always @(posedge clk) begin
		sample_t s;
		if (push && !full) begin
			expected_verdicts.push_back(predict_cost(pending_samples.pop_front()));
		end
		if (push_gap > 0) begin
			push_gap <= push_gap - 1;
			push <= 1'b0;
		end else if ((push && full) || pending_samples.size() == 0 ||
				!(push && !full) && push) begin
			push <= (pending_samples.size() != 0);
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			push_gap <= $urandom_range(1, 13) - 1;
			push <= 1'b0;
		end else begin
			s = pending_samples[0];
			push <= 1'b1;
			{alert_h, alert_v, prot_h, prot_v, all_finite} <= s;
		end
	end

	// result monitor
	always @(posedge clk) begin
		verdict_t v, got;
		if (pop && !empty) begin
			got = {valid_out, input_ok, margin_h_out, margin_v_out, min_margin, cost_h,
				cost_v, ratio_pen, total_cost, clamp_hit, risk_code, tight_axis};
			if (expected_verdicts.size() == 0) begin
				$display("%0t: result beat with none expected: %p", $time, got);
				errors++;
			end else begin
				v = expected_verdicts.pop_front();
				if (got.vld !== v.vld) begin $display("%0t valid_out exp %h got %h", $time, v.vld, got.vld); errors++; end
				if (got.ok !== v.ok) begin $display("%0t input_ok exp %h got %h", $time, v.ok, got.ok); errors++; end
				if (got.mh !== v.mh) begin $display("%0t margin_h_out exp %h got %h", $time, v.mh, got.mh); errors++; end
				if (got.mv !== v.mv) begin $display("%0t margin_v_out exp %h got %h", $time, v.mv, got.mv); errors++; end
				if (got.mmin !== v.mmin) begin $display("%0t min_margin exp %h got %h", $time, v.mmin, got.mmin); errors++; end
				if (got.ch !== v.ch) begin $display("%0t cost_h exp %h got %h", $time, v.ch, got.ch); errors++; end
				if (got.cv !== v.cv) begin $display("%0t cost_v exp %h got %h", $time, v.cv, got.cv); errors++; end
				if (got.rc !== v.rc) begin $display("%0t ratio_pen exp %h got %h", $time, v.rc, got.rc); errors++; end
				if (got.tot !== v.tot) begin $display("%0t total_cost exp %h got %h", $time, v.tot, got.tot); errors++; end
				if (got.clmp !== v.clmp) begin $display("%0t clamp_hit exp %h got %h", $time, v.clmp, got.clmp); errors++; end
				if (got.risk !== v.risk) begin $display("%0t risk_code exp %h got %h", $time, v.risk, got.risk); errors++; end
				if (got.dom !== v.dom) begin $display("%0t tight_axis exp %h got %h", $time, v.dom, got.dom); errors++; end
			end
		end
		if (pop_gap > 0) begin
			pop_gap <= pop_gap - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			pop_gap <= $urandom_range(1, 13) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// register write while idle
	task automatic write_reg(reg_idx_t idx, logic [CB-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_MODE_FLAGS: sh_mode = val[3:0];
			REG_MAX_COST:   sh_max = val;
			REG_EPS_LIMIT:  sh_eps = val[LB-1:0];
			REG_MARGIN_H:   sh_mh = val[LB-1:0];
			REG_MARGIN_V:   sh_mv = val[LB-1:0];
			REG_GAIN_H:     sh_gh = val[15:0];
			REG_GAIN_V:     sh_gv = val[15:0];
			default:        sh_mu = val[15:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic drain;
		wait (pending_samples.size() == 0 && !push);
		wait (expected_verdicts.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [LB-1:0] rand_len();
		case ($urandom_range(0, 5))
			0: return LEN_MAX - LB'($urandom_range(0, 3));
			1: return LB'($urandom_range(0, 4));
			2: return LB'($urandom_range(0, 4096));
			default: return LB'($urandom());
		endcase
	endfunction

	task automatic queue_random(int n);
		sample_t s;
		logic [LB-1:0] d;
		repeat (n) begin
			s.ah = rand_len();
			s.av = rand_len();
			// protection near the limit most of the time
			if ($urandom_range(0, 3) != 0) begin
				d = LB'($urandom_range(0, 2048));
				s.ph = (s.ah > d) ? s.ah - d + LB'($urandom_range(0, 1024))
				                  : LB'($urandom_range(0, 2048));
				s.pv = (s.av > d) ? s.av - LB'($urandom_range(0, 2048))
				                  : LB'($urandom_range(0, 2048));
			end else begin
				s.ph = rand_len();
				s.pv = rand_len();
			end
			s.fin = ($urandom_range(0, 9) != 0);
			pending_samples.push_back(s);
		end
	endtask

	task automatic random_config(bit wide);
		write_reg(REG_MODE_FLAGS, CB'($urandom_range(0, 15)));
		write_reg(REG_MAX_COST, wide ? CB'({$urandom(), $urandom()}) : CB'($urandom_range(0, 1 << 30)));
		write_reg(REG_EPS_LIMIT, CB'($urandom_range(0, 3) == 0 ? LB'($urandom()) : LB'($urandom_range(0, 300))));
		write_reg(REG_MARGIN_H, CB'($urandom_range(0, 3) == 0 ? LB'($urandom()) : LB'($urandom_range(0, 2048))));
		write_reg(REG_MARGIN_V, CB'($urandom_range(0, 3) == 0 ? LB'($urandom()) : LB'($urandom_range(0, 2048))));
		write_reg(REG_GAIN_H, CB'($urandom_range(0, 65535)));
		write_reg(REG_GAIN_V, CB'($urandom_range(0, 65535)));
		write_reg(REG_MU_RATIO, CB'($urandom_range(0, 65535)));
	endtask

	// stimulus
	initial begin
		mode_t md;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		// directed corners at reset settings
		pending_samples.push_back({LEN_MAX, LEN_MAX, 24'd0, 24'd0, 1'b1});
		pending_samples.push_back({24'd0, 24'd0, LEN_MAX, LEN_MAX, 1'b1});
		pending_samples.push_back({24'd1, 24'd2, 24'd0, 24'd0, 1'b1});
		pending_samples.push_back({24'd1000, 24'd1000, 24'd900, 24'd900, 1'b1});
		pending_samples.push_back({24'd5000, 24'd3000, 24'd100, 24'd200, 1'b1});
		pending_samples.push_back({24'd3000, 24'd5000, 24'd100, 24'd200, 1'b1});
		pending_samples.push_back({24'd3000, 24'd5000, 24'd100, 24'd200, 1'b0});
		pending_samples.push_back({LEN_MAX, 24'd2, LEN_MAX, LEN_MAX, 1'b1});
		drain();
		// extremes: ratio and hinge at full weight, largest cap, then a zero cap
		md = '{ratio: 1'b1, hinge: 1'b1, penalize: 1'b1, unified: 1'b1};
		write_reg(REG_MODE_FLAGS, CB'(md));
		write_reg(REG_MU_RATIO, CB'(16'hFFFF));
		write_reg(REG_GAIN_H, CB'(16'hFFFF));
		write_reg(REG_EPS_LIMIT, CB'(24'd0));
		write_reg(REG_MAX_COST, COST_SAT);
		pending_samples.push_back({24'd1, 24'd1, LEN_MAX, LEN_MAX, 1'b1});
		pending_samples.push_back({24'd0, 24'd5, 24'd3, 24'd3, 1'b1});
		pending_samples.push_back({24'd7, 24'd5, 24'd3, 24'd9, 1'b0});
		pending_samples.push_back({LEN_MAX, LEN_MAX, LEN_MAX, 24'd0, 1'b1});
		drain();
		write_reg(REG_MAX_COST, '0);
		write_reg(REG_EPS_LIMIT, CB'(LEN_MAX));
		write_reg(REG_MARGIN_H, CB'(LEN_MAX));
		write_reg(REG_MARGIN_V, CB'(LEN_MAX));
		pending_samples.push_back({LEN_MAX, LEN_MAX, 24'd0, 24'd0, 1'b1});
		pending_samples.push_back({24'd100, 24'd100, 24'd0, 24'd0, 1'b1});
		drain();
		// legacy mode with separate weights
		md = '{ratio: 1'b0, hinge: 1'b0, penalize: 1'b1, unified: 1'b0};
		write_reg(REG_MODE_FLAGS, CB'(md));
		write_reg(REG_GAIN_V, CB'(16'hFFFF));
		write_reg(REG_GAIN_H, CB'(16'h0000));
		write_reg(REG_MARGIN_H, CB'(24'd256));
		pending_samples.push_back({24'd10, 24'd20, LEN_MAX, LEN_MAX, 1'b1});
		pending_samples.push_back({24'd500, 24'd300, 24'd400, 24'd300, 1'b1});
		pending_samples.push_back({24'd500, 24'd300, 24'd400, 24'd300, 1'b0});
		pending_samples.push_back({LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, 1'b1});
		drain();
		// random phases over varied settings
		for (int ph = 0; ph < 8; ph++) begin
			random_config(ph[0]);
			if (ph == 7) calm = 1;
			queue_random(140);
			drain();
		end
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
